// ===== sv/apr_pkg.sv =====
package apr_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 7;
  localparam int LEVEL_W    = 18;
  localparam int COUNT_W    = 32;
  localparam int CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GAIN  = 2'd3;

  localparam logic [GAIN_W-1:0]  UNITY_GAIN        = 16'd32768;
  localparam logic [LEVEL_W-1:0] DEFAULT_PREBUFFER = 18'd44100;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [LEN_W-1:0]           read_length;
    logic [GAIN_W-1:0]          gain_value;
  } apr_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       is_real;
    logic                       last;
    logic [LEVEL_W-1:0]         fill_level;
    logic [COUNT_W-1:0]         underrun_count;
    logic [COUNT_W-1:0]         dropped_count;
  } apr_out_t;

  // tag that travels alongside a sample through the read pipeline
  typedef struct packed {
    logic valid;
    logic is_real;
    logic last;
  } apr_tag_t;

endpackage

// ===== sv/apr_scale.sv =====
module apr_scale
  import apr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  apr_tag_t                   tag_in,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [GAIN_W-1:0]          gain,
  output apr_tag_t                   tag_out,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

  apr_tag_t                   tag1_r;
  apr_tag_t                   tag2_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] result_r;
  logic signed [PROD_W-1:0]   rnd;

  // round half up, then drop the 15 fraction bits
  assign rnd = prod_r + PROD_W'(16384);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= sample * $signed({1'b0, gain});
    result_r <= tag1_r.is_real ? rnd[SAMPLE_W+14:15] : '0;
  end

  assign tag_out = tag2_r;
  assign result  = result_r;

endmodule

// ===== sv/audio_playout_ring_buffer.sv =====
// channel | ports                          | handshake
// --------+--------------------------------+---------------------------------
// input   | start, busy, in_data           | word taken when start && !busy
// result  | out_valid, out_data            | one-cycle strobe, no back-pressure
// config  | cfg_valid, cfg_ready, cfg_data | written when cfg_valid && cfg_ready
//
// push, clear and set gain may follow back to back
// a read of L words keeps busy high while L memory reads are issued
//   one per cycle from the sample ram and pass the two-stage gain multiplier
// reset (rst_n low, synchronous) empties the ring, arms prebuffering, sets
//   unity gain; the sample ram itself is not cleared and needs no sweep
// the receiver cannot stall: results leave on out_valid as they are made
module audio_playout_ring_buffer
  import apr_pkg::*;
#(
  parameter int RING_DEPTH = 131072,
  parameter int MAX_READ   = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 start,
  output logic                 busy,
  input  apr_in_t              in_data,
  // result words
  output logic                 out_valid,
  output apr_out_t             out_data,
  // prebuffer level register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LEVEL_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int CMP_W  = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // sample ram
  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] mem_q_r;

  // control state
  state_t              state_r, state_nxt;
  logic                busy_r, busy_nxt;
  logic [ADDR_W-1:0]   rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic                prebuf_r, prebuf_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [COUNT_W-1:0]  dropped_r, dropped_nxt;
  logic [COUNT_W-1:0]  underrun_r, underrun_nxt;
  logic [LEVEL_W-1:0]  level_r;

  // read block sequencing
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    n_r, n_nxt;
  logic [LEN_W-1:0]    idx_r, idx_nxt;
  logic                zero_r, zero_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  apr_tag_t            tag0_r, tag0_nxt;

  logic                accept;
  logic                full;
  logic [SUM_W-1:0]    tail_sum;
  logic [ADDR_W-1:0]   tail;
  logic [ADDR_W-1:0]   pos_inc;
  logic                wr_en;
  logic [LEN_W-1:0]    len;
  logic [LEVEL_W-1:0]  thr_raw;
  logic [CMP_W-1:0]    thr;
  logic                wait_fill;
  logic [LEN_W-1:0]    n_take;
  logic [SUM_W-1:0]    pos_sum;
  logic                issue_real;
  logic                issue_last;

  apr_tag_t                   scl_tag;
  logic signed [SAMPLE_W-1:0] scl_result;

  assign accept    = start && !busy_r;
  assign full      = (fill_r == CNT_W'(RING_DEPTH));

  // next read position, used when the oldest sample is dropped
  assign pos_inc = (rd_pos_r == ADDR_W'(RING_DEPTH - 1)) ? '0 : rd_pos_r + 1'b1;

  // write slot: a full ring reuses the slot of the dropped sample
  assign tail_sum = SUM_W'(rd_pos_r) + SUM_W'(fill_r);
  always_comb begin
    if (full) begin
      tail = rd_pos_r;
    end else if (tail_sum >= SUM_W'(RING_DEPTH)) begin
      tail = ADDR_W'(tail_sum - SUM_W'(RING_DEPTH));
    end else begin
      tail = tail_sum[ADDR_W-1:0];
    end
  end

  assign wr_en = accept && (in_data.command == CMD_PUSH);

  // read length, capped at the largest block
  assign len = (in_data.read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ)
                                                        : in_data.read_length;

  // playout threshold: min(depth, max(level, len))
  assign thr_raw = (level_r > LEVEL_W'(len)) ? level_r : LEVEL_W'(len);
  assign thr     = (CMP_W'(thr_raw) > CMP_W'(RING_DEPTH)) ? CMP_W'(RING_DEPTH)
                                                           : CMP_W'(thr_raw);
  assign wait_fill = prebuf_r && (CMP_W'(fill_r) < thr);

  assign n_take  = (CNT_W'(len) < fill_r) ? len : LEN_W'(fill_r);
  assign pos_sum = SUM_W'(rd_pos_r) + SUM_W'(n_take);

  assign issue_real = !zero_r && (idx_r < n_r);
  assign issue_last = (idx_r == len_r - 1'b1);

  always_comb begin
    state_nxt    = state_r;
    busy_nxt     = busy_r;
    rd_pos_nxt   = rd_pos_r;
    fill_nxt     = fill_r;
    prebuf_nxt   = prebuf_r;
    gain_nxt     = gain_r;
    dropped_nxt  = dropped_r;
    underrun_nxt = underrun_r;
    len_nxt      = len_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    zero_nxt     = zero_r;
    addr_nxt     = addr_r;
    tag0_nxt     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_PUSH: begin
              if (full) begin
                rd_pos_nxt  = pos_inc;
                dropped_nxt = (dropped_r == COUNT_MAX) ? dropped_r : dropped_r + 1'b1;
                fill_nxt    = fill_r;
              end else begin
                fill_nxt = fill_r + 1'b1;
              end
            end
            CMD_CLEAR: begin
              rd_pos_nxt = '0;
              fill_nxt   = '0;
              prebuf_nxt = 1'b1;
            end
            CMD_GAIN: begin
              gain_nxt = (in_data.gain_value > UNITY_GAIN) ? UNITY_GAIN
                                                           : in_data.gain_value;
            end
            CMD_READ: begin
              if (len != '0) begin
                state_nxt = ST_RUN;
                busy_nxt  = 1'b1;
                len_nxt   = len;
                idx_nxt   = '0;
                addr_nxt  = rd_pos_r;
                zero_nxt  = len[0] || wait_fill;
                n_nxt     = n_take;
                // a block that plays commits its ring update up front
                if (!(len[0] || wait_fill)) begin
                  prebuf_nxt = 1'b0;
                  fill_nxt   = fill_r - CNT_W'(n_take);
                  if (pos_sum >= SUM_W'(RING_DEPTH)) begin
                    rd_pos_nxt = ADDR_W'(pos_sum - SUM_W'(RING_DEPTH));
                  end else begin
                    rd_pos_nxt = pos_sum[ADDR_W-1:0];
                  end
                  if (n_take < len) begin
                    prebuf_nxt   = 1'b1;
                    underrun_nxt = (underrun_r == COUNT_MAX) ? underrun_r
                                                             : underrun_r + 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        tag0_nxt.valid   = 1'b1;
        tag0_nxt.is_real = issue_real;
        tag0_nxt.last    = issue_last;
        idx_nxt          = idx_r + 1'b1;
        if (issue_real) begin
          addr_nxt = (addr_r == ADDR_W'(RING_DEPTH - 1)) ? '0 : addr_r + 1'b1;
        end
        if (issue_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // busy drops once the last word of the block has gone out
    if (scl_tag.valid && scl_tag.last) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      busy_r     <= 1'b0;
      rd_pos_r   <= '0;
      fill_r     <= '0;
      prebuf_r   <= 1'b1;
      gain_r     <= UNITY_GAIN;
      dropped_r  <= '0;
      underrun_r <= '0;
      level_r    <= DEFAULT_PREBUFFER;
      tag0_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      busy_r     <= busy_nxt;
      rd_pos_r   <= rd_pos_nxt;
      fill_r     <= fill_nxt;
      prebuf_r   <= prebuf_nxt;
      gain_r     <= gain_nxt;
      dropped_r  <= dropped_nxt;
      underrun_r <= underrun_nxt;
      tag0_r     <= tag0_nxt;
      if (cfg_valid && cfg_ready) begin
        level_r <= cfg_data;
      end
    end
  end

  // block bookkeeping needs no reset
  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    zero_r <= zero_nxt;
    addr_r <= addr_nxt;
  end

  // sample ram: write on push, registered read while streaming a block;
  // pushes are only taken while idle, so a read never meets a write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= in_data.sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      mem_q_r <= mem[addr_r];
    end
  end

  apr_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag0_r),
    .sample  ($signed(mem_q_r)),
    .gain    (gain_r),
    .tag_out (scl_tag),
    .result  (scl_result)
  );

  // ring state is frozen while busy, so the totals go out straight from it
  assign busy                    = busy_r;
  assign cfg_ready               = !busy_r;
  assign out_valid               = scl_tag.valid;
  assign out_data.sample_out     = scl_result;
  assign out_data.is_real        = scl_tag.is_real;
  assign out_data.last           = scl_tag.last;
  assign out_data.fill_level     = LEVEL_W'(fill_r);
  assign out_data.underrun_count = underrun_r;
  assign out_data.dropped_count  = dropped_r;

  // results only appear inside a busy window
  a_out_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result word outside a read block");

  // the last word of a block frees the input
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> !busy_r)
    else $error("busy held after last word");

  // a non-empty read claims the block
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == CMD_READ && len != '0) |=> busy_r)
    else $error("read block not started");

  // the ring never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(RING_DEPTH))
    else $error("fill count above ring depth");

endmodule

// ===== bench/audio_playout_ring_buffer_tb.sv =====
import apr_pkg::*;

// geometry of the block under test, shared by the model and the instance
localparam int RING_SLOTS = 131072;
localparam int READ_CAP   = 64;

// playout model: holds its own copy of the ring and the counters and queues
// the words that each read block must produce
class playout_scoreboard;
  bit [SAMPLE_W-1:0]  ring [RING_SLOTS];
  int unsigned        head;
  int unsigned        fill;
  bit                 prebuffering;
  logic [GAIN_W-1:0]  gain;
  logic [LEVEL_W-1:0] level;
  logic [COUNT_W-1:0] dropped;
  logic [COUNT_W-1:0] underruns;
  apr_out_t           pending_playout[$];
  int unsigned        mismatches;
  int unsigned        commands;
  int unsigned        reads;
  int unsigned        real_words;
  int unsigned        zero_words;

  function new();
    head         = 0;
    fill         = 0;
    prebuffering = 1'b1;
    gain         = UNITY_GAIN;
    level        = DEFAULT_PREBUFFER;
    dropped      = '0;
    underruns    = '0;
    mismatches   = 0;
    commands     = 0;
    reads        = 0;
    real_words   = 0;
    zero_words   = 0;
  endfunction

  function logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // round to nearest, ties toward plus infinity
  function logic [SAMPLE_W-1:0] apply_gain(input bit [SAMPLE_W-1:0] raw);
    longint prod;
    longint q;
    prod = longint'($signed(raw)) * longint'(gain) + 64'sd16384;
    q = prod >>> 15;
    return q[SAMPLE_W-1:0];
  endfunction

  function void set_level(input logic [LEVEL_W-1:0] v);
    level = v;
  endfunction

  function void take_command(input apr_in_t w);
    int unsigned len;
    int unsigned thr;
    int unsigned n;
    int unsigned pos;
    bit          zeros;
    apr_out_t    r;
    commands++;
    case (w.command)
      CMD_PUSH: begin
        if (fill >= RING_SLOTS) begin
          head    = (head + 1) % RING_SLOTS;
          fill    = RING_SLOTS - 1;
          dropped = bump(dropped);
        end
        ring[(head + fill) % RING_SLOTS] = w.sample_in;
        fill++;
      end
      CMD_CLEAR: begin
        head         = 0;
        fill         = 0;
        prebuffering = 1'b1;
      end
      CMD_GAIN: begin
        gain = (w.gain_value > UNITY_GAIN) ? UNITY_GAIN : w.gain_value;
      end
      default: begin
        len = w.read_length;
        if (len > READ_CAP) len = READ_CAP;
        if (len != 0) begin
          reads++;
          n     = 0;
          zeros = (len % 2) == 1;
          if (!zeros) begin
            thr = (level > len) ? level : len;
            if (thr > RING_SLOTS) thr = RING_SLOTS;
            if (prebuffering && fill < thr) zeros = 1'b1;
          end
          pos = head;
          if (!zeros) begin
            prebuffering = 1'b0;
            n    = (len < fill) ? len : fill;
            fill = fill - n;
            head = (head + n) % RING_SLOTS;
            if (n < len) begin
              prebuffering = 1'b1;
              underruns    = bump(underruns);
            end
          end
          for (int i = 0; i < len; i++) begin
            r.is_real        = (i < n);
            r.sample_out     = (i < n) ? apply_gain(ring[pos]) : '0;
            r.last           = (i == len - 1);
            r.fill_level     = LEVEL_W'(fill);
            r.underrun_count = underruns;
            r.dropped_count  = dropped;
            if (i < n) pos = (pos + 1) % RING_SLOTS;
            pending_playout.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function void check_playout(input apr_out_t got);
    apr_out_t want;
    if (pending_playout.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: sample %h real %b last %b", got.sample_out, got.is_real,
                 got.last);
      return;
    end
    want = pending_playout.pop_front();
    if (want.is_real) real_words++;
    else zero_words++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch exp: sample %h real %b last %b fill %0d under %0d drop %0d",
                 want.sample_out, want.is_real, want.last, want.fill_level,
                 want.underrun_count, want.dropped_count);
        $display("         got: sample %h real %b last %b fill %0d under %0d drop %0d",
                 got.sample_out, got.is_real, got.last, got.fill_level,
                 got.underrun_count, got.dropped_count);
      end
    end
  endfunction
endclass

module audio_playout_ring_buffer_tb;

  // cycle budget for the whole run, enforced by the watchdog
  localparam int CYCLE_LIMIT  = 1000000;
  // settle time after the last word: a read pipeline is three stages deep
  localparam int SETTLE_TICKS = 8;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  apr_in_t            in_data;
  logic               out_valid;
  apr_out_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LEVEL_W-1:0] cfg_data;

  // chance in percent that the sender holds off before a command word
  int                 idle_pct;

  playout_scoreboard  board = new();

  audio_playout_ring_buffer #(
    .RING_DEPTH (RING_SLOTS),
    .MAX_READ   (READ_CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one sampling process at the rising edge: accepted command words and
  // register writes update the model before the result word of that edge
  // is checked, so nothing hangs on event order within the step
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.take_command(in_data);
      if (cfg_valid && cfg_ready) board.set_level(cfg_data);
      if (out_valid) board.check_playout(out_data);
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timed out with %0d words outstanding", board.pending_playout.size());
    $display("FAILURE");
    $finish;
  end

  // every field random, then the command fixed; unused fields stay random
  function automatic apr_in_t make_word(input logic [CMD_W-1:0] cmd);
    apr_in_t     w;
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    w.command     = cmd;
    w.sample_in   = a[SAMPLE_W-1:0];
    w.read_length = b[LEN_W-1:0];
    w.gain_value  = b[31:16];
    return w;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(7))
      0:       return 8388607;
      1:       return -8388608;
      default: return int'($urandom);
    endcase
  endfunction

  // hold start until the block takes the word; start stays high afterwards
  // so that back-to-back words need no extra edge
  task automatic send(input apr_in_t w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  // the value lands in whichever field the command uses
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int value);
    apr_in_t w;
    w = make_word(cmd);
    case (cmd)
      CMD_PUSH: w.sample_in   = value[SAMPLE_W-1:0];
      CMD_READ: w.read_length = value[LEN_W-1:0];
      CMD_GAIN: w.gain_value  = value[GAIN_W-1:0];
      default: ;
    endcase
    send(w);
  endtask

  // sender pauses until every predicted word is out and the block is idle
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_playout.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register writes only land on an idle block
  task automatic write_level(input int v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[LEVEL_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly fill-then-read sequences with random content, the rest noise
  task automatic run_phase(input int pct, input int lvl, input int quota);
    int sent;
    int pushes;
    write_level(lvl);
    idle_pct = pct;
    sent     = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 75) begin
        pushes = $urandom_range(4, 40);
        repeat (pushes) send_cmd(CMD_PUSH, pick_sample());
        if ($urandom_range(9) == 0) begin
          send_cmd(CMD_GAIN, $urandom_range(0, 32768));
          sent++;
        end
        send_cmd(CMD_READ, 2 * $urandom_range(1, 20));
        sent += pushes + 1;
      end else begin
        // noise: any command, any field content, odd and overlong reads
        send(make_word(CMD_W'($urandom_range(3))));
        sent++;
      end
      if ($urandom_range(99) == 0) drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_pct  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default prebuffer level: a short fill only ever plays zeros
    send_cmd(CMD_PUSH, 8388607);
    send_cmd(CMD_READ, 2);

    // directed corner cases at a low threshold
    write_level(4);
    send_cmd(CMD_READ, 0);          // zero length read, no words
    send_cmd(CMD_READ, 3);          // odd length read, zeros only
    send_cmd(CMD_PUSH, -8388608);
    send_cmd(CMD_PUSH, -1);
    send_cmd(CMD_READ, 2);          // fill still under threshold, waits
    send_cmd(CMD_PUSH, 1);
    send_cmd(CMD_PUSH, 0);
    send_cmd(CMD_READ, 4);          // playout starts at unity gain
    send_cmd(CMD_GAIN, 16'hffff);   // above unity, clamps to unity
    send_cmd(CMD_GAIN, 16384);
    send_cmd(CMD_PUSH, 24'h555555);
    send_cmd(CMD_PUSH, -24'sh555555);
    send_cmd(CMD_READ, 2);          // half gain, rounding ties upward
    send_cmd(CMD_GAIN, 1);
    send_cmd(CMD_READ, 127);        // overlong read, capped, underruns
    send_cmd(CMD_GAIN, 0);
    send_cmd(CMD_PUSH, 8388607);
    send_cmd(CMD_CLEAR, 0);
    send_cmd(CMD_READ, 2);          // empty after clear
    send_cmd(CMD_GAIN, 32768);

    // threshold far above the ring size is capped at the depth, a short
    // fill still waits
    write_level(2 ** LEVEL_W - 1);
    repeat (6) send_cmd(CMD_PUSH, pick_sample());
    send_cmd(CMD_READ, 2);
    send_cmd(CMD_CLEAR, 0);

    // random traffic: sender idles at times, then often, then never
    run_phase(34, $urandom_range(1, 48), 150);
    run_phase(84, 0, 150);
    run_phase(0, $urandom_range(24, 80), 150);

    drain();
    $display("covered %0d commands, %0d reads: %0d played and %0d zero-fill words checked",
             board.commands, board.reads, board.real_words, board.zero_words);
    $display("ring overflow dropped %0d samples, %0d underruns seen, %0d mismatches",
             board.dropped, board.underruns, board.mismatches);
    if (board.mismatches == 0 && board.pending_playout.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d words never arrived", board.pending_playout.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
